[rtl/plh_pkg.sv]
// Shared constants and field widths for the packet latency histogram.
package plh_pkg;

  localparam int RINGS_DEF = 16;
  localparam int SLOTS_DEF = 1024;

  localparam int MODE_W   = 2;
  localparam int RING_W   = 4;
  localparam int TIME_W   = 64;
  localparam int BIN_W    = 10;
  localparam int DIVISOR_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_STAMP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLES_PER_NS   = 1'b1;

endpackage

[rtl/plh_if.sv]
// Item and result channel interfaces.
interface plh_item_if;
  import plh_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [RING_W-1:0]   ring;
  logic [TIME_W-1:0]   now_time;
  logic [TIME_W-1:0]   packet_stamp;
  logic [BIN_W-1:0]    bin;

  modport source (output valid, mode, ring, now_time, packet_stamp, bin, input ready);
  modport sink   (input valid, mode, ring, now_time, packet_stamp, bin, output ready);
endinterface

interface plh_result_if;
  import plh_pkg::*;
  logic                valid;
  logic                ready;
  logic                stamped;
  logic [TIME_W-1:0]   stamp_value;
  logic [TIME_W-1:0]   bin_count;

  modport source (output valid, stamped, stamp_value, bin_count, input ready);
  modport sink   (input valid, stamped, stamp_value, bin_count, output ready);
endinterface

[rtl/plh_ram.sv]
// Generic single-port RAM with registered read.
module plh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/plh_div.sv]
// Sequential 64 by 7 bit unsigned divider, eight quotient bits per cycle.
module plh_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [plh_pkg::TIME_W-1:0]      dividend,
  input  logic [plh_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            done,
  output logic [plh_pkg::TIME_W-1:0]      quotient
);
  import plh_pkg::*;

  localparam int BITS_PER_CYCLE = 8;
  localparam int STEPS = TIME_W / BITS_PER_CYCLE;
  localparam int STEP_W = $clog2(STEPS);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [TIME_W-1:0]     num;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [TIME_W-1:0]     num_next;
  logic [DIVISOR_W-1:0]  rem_next;

  always_comb begin
    logic [DIVISOR_W:0] r;
    num_next = num;
    rem_next = rem;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      r = {rem_next, num_next[TIME_W-1]};
      num_next = {num_next[TIME_W-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        rem_next = DIVISOR_W'(r - {1'b0, dvs});
        num_next[0] = 1'b1;
      end else begin
        rem_next = r[DIVISOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        num  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        num  <= num_next;
        rem  <= rem_next;
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = num;

endmodule

[rtl/packet_latency_histogram_core.sv]
// Top level: per-ring sampled latency stamping and latency histogram.
// Usage:
//   item channel (valid/ready) carries one packet event word: mode, ring,
//   now_time, packet_stamp, bin. result channel returns exactly one word per
//   item: stamped, stamp_value, bin_count. Configuration is a plain write
//   port (cfg_write, cfg_index, cfg_data), to be written only while idle;
//   the user is bound by this, as the block itself does not enforce it.
// Path from accept to result valid: stamp goes through lookup and
//   accumulate, read through lookup, measure with a stamp waits on the
//   divider and then does a histogram read and write, and anything that
//   touches no state goes straight to the done state. One item is in
//   work at a time; the next item is taken in the cycle after the result
//   is registered.
// Reset: a clearing pass zeroes the ring table and every histogram bin;
//   no item is taken during it. Registers reset to interval 0, divisor 1.
// Stall: the result sits in an output register; a new item is accepted
//   while it waits, but its own result is held back until the slot frees.
module packet_latency_histogram_core #(
  parameter int RINGS = plh_pkg::RINGS_DEF,
  parameter int SLOTS = plh_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  plh_item_if.sink                        item,
  plh_result_if.source                    result,
  input  logic                            cfg_write,
  input  logic [plh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plh_pkg::TIME_W-1:0]      cfg_data
);
  import plh_pkg::*;

  localparam int RW = (RINGS > 1) ? $clog2(RINGS) : 1;
  localparam int SW = $clog2(SLOTS);
  localparam int AW = RW + SW;
  localparam logic [TIME_W-1:0] SLOT_LAST = TIME_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_ACCUM, S_DIVIDE, S_COUNT_RD, S_COUNT_WR, S_DONE
  } state_t;

  state_t state;

  logic [TIME_W-1:0]     cfg_interval;
  logic [DIVISOR_W-1:0]  cfg_divisor;

  logic [AW-1:0]         clr_addr;
  logic [MODE_W-1:0]     it_mode;
  logic [RW-1:0]         it_ring;
  logic [TIME_W-1:0]     it_now;
  logic                  it_bin_ok;
  logic [SW-1:0]         slot;
  logic [TIME_W-1:0]     sum;

  logic                  res_stamped;
  logic [TIME_W-1:0]     res_stamp_value;
  logic [TIME_W-1:0]     res_bin_count;
  logic                  out_valid;
  logic                  res_load;

  logic                  ring_we;
  logic [RW-1:0]         ring_addr;
  logic [2*TIME_W-1:0]   ring_wdata;
  logic [2*TIME_W-1:0]   ring_rdata;
  logic                  cnt_we;
  logic [AW-1:0]         cnt_addr;
  logic [TIME_W-1:0]     cnt_wdata;
  logic [TIME_W-1:0]     cnt_rdata;

  logic                  ring_ok;
  logic                  div_start;
  logic                  div_done;
  logic [TIME_W-1:0]     div_quot;
  logic [DIVISOR_W-1:0]  divisor_eff;
  logic                  stamp_hit;

  assign ring_ok     = 32'(item.ring) < RINGS;
  assign divisor_eff = (cfg_divisor == '0) ? DIVISOR_W'(1) : cfg_divisor;
  assign div_start   = (state == S_IDLE) && item.valid && ring_ok &&
                       (item.mode == MODE_MEASURE) && (item.packet_stamp != '0);
  assign stamp_hit   = sum >= cfg_interval;
  assign res_load    = (state == S_DONE) && (!out_valid || result.ready);

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;

  plh_ram #(.WIDTH(2 * TIME_W), .DEPTH(2 ** RW)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .addr  (ring_addr),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  plh_ram #(.WIDTH(TIME_W), .DEPTH(2 ** AW)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  plh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (item.now_time - item.packet_stamp),
    .divisor  (divisor_eff),
    .done     (div_done),
    .quotient (div_quot)
  );

  // ring table word: {accumulator, previous time}
  always_comb begin
    ring_we    = 1'b0;
    ring_addr  = it_ring;
    ring_wdata = {(stamp_hit ? {TIME_W{1'b0}} : sum), it_now};
    cnt_we     = 1'b0;
    cnt_addr   = {it_ring, slot};
    cnt_wdata  = cnt_rdata + 1'b1;
    unique case (state)
      S_CLEAR: begin
        ring_we    = 1'b1;
        ring_addr  = clr_addr[RW-1:0];
        ring_wdata = '0;
        cnt_we     = 1'b1;
        cnt_addr   = clr_addr;
        cnt_wdata  = '0;
      end
      S_IDLE: begin
        ring_addr = RW'(item.ring);
        cnt_addr  = {RW'(item.ring), SW'(item.bin)};
      end
      S_ACCUM:    ring_we = 1'b1;
      S_COUNT_WR: cnt_we = 1'b1;
      S_LOOKUP, S_DIVIDE, S_COUNT_RD, S_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      out_valid    <= 1'b0;
      cfg_interval <= '0;
      cfg_divisor  <= DIVISOR_W'(1);
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_SAMPLE_INTERVAL) begin
          cfg_interval <= cfg_data;
        end else begin
          cfg_divisor <= cfg_data[DIVISOR_W-1:0];
        end
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item.valid) begin
            it_mode         <= item.mode;
            it_ring         <= RW'(item.ring);
            it_now          <= item.now_time;
            it_bin_ok       <= 32'(item.bin) < SLOTS;
            res_stamped     <= 1'b0;
            res_stamp_value <= '0;
            res_bin_count   <= '0;
            if (!ring_ok) begin
              state <= S_DONE;
            end else begin
              case (item.mode)
                MODE_STAMP, MODE_READ: state <= S_LOOKUP;
                MODE_MEASURE: state <= (item.packet_stamp != '0) ? S_DIVIDE : S_DONE;
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_LOOKUP: begin
          if (it_mode == MODE_READ) begin
            res_bin_count <= it_bin_ok ? cnt_rdata : '0;
            state         <= S_DONE;
          end else begin
            sum   <= ring_rdata[2*TIME_W-1:TIME_W] + it_now - ring_rdata[TIME_W-1:0];
            state <= S_ACCUM;
          end
        end
        S_ACCUM: begin
          if (stamp_hit) begin
            res_stamped     <= 1'b1;
            res_stamp_value <= it_now;
          end
          state <= S_DONE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            slot  <= (div_quot >= SLOT_LAST) ? SW'(SLOTS - 1) : div_quot[SW-1:0];
            state <= S_COUNT_RD;
          end
        end
        S_COUNT_RD: state <= S_COUNT_WR;
        S_COUNT_WR: state <= S_DONE;
        S_DONE: begin
          if (res_load) begin
            result.stamped     <= res_stamped;
            result.stamp_value <= res_stamp_value;
            result.bin_count   <= res_bin_count;
            state              <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !item.ready)
    else $error("item ready during clearing pass");
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVIDE))
    else $error("divider finished outside divide state");
  a_count_write_place: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (state == S_CLEAR || state == S_COUNT_WR))
    else $error("histogram written outside clear or update");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state != S_IDLE))
    else $error("accepted word did not start work");
`endif

endmodule

[tb/tb_packet_latency_histogram_core.sv]
// Self-checking testbench for packet_latency_histogram_core: stamping, histogram and bin reads.
`timescale 1ns / 1ps

module tb_packet_latency_histogram_core;
  import plh_pkg::*;

  localparam int RINGS = RINGS_DEF;
  localparam int SLOTS = SLOTS_DEF;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct packed {
    logic              stamped;
    logic [TIME_W-1:0] stamp_value;
    logic [TIME_W-1:0] bin_count;
  } latency_result_t;

  typedef struct {
    logic [RING_W-1:0] ring;
    logic [TIME_W-1:0] stamp;
  } open_stamp_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0] cfg_data;

  plh_item_if item_ch ();
  plh_result_if result_ch ();

  packet_latency_histogram_core dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow state
  logic [TIME_W-1:0] interval_reg;
  logic [DIVISOR_W-1:0] ns_divisor;
  logic [TIME_W-1:0] last_seen [RINGS];
  logic [TIME_W-1:0] gap_sum [RINGS];
  logic [TIME_W-1:0] hist_count [RINGS*SLOTS];

  latency_result_t pending_results [$];
  open_stamp_t open_stamps [$];
  logic [TIME_W-1:0] ring_clock [RINGS];
  logic [BIN_W-1:0] recent_bin [RINGS];

  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int idle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_shadow();
    interval_reg = '0;
    ns_divisor = 7'd1;
    for (int r = 0; r < RINGS; r++) begin
      last_seen[r] = '0;
      gap_sum[r] = '0;
      ring_clock[r] = '0;
      recent_bin[r] = '0;
    end
    for (int i = 0; i < RINGS*SLOTS; i++) hist_count[i] = '0;
  endfunction

  function automatic latency_result_t predict_latency_result(
      input logic [MODE_W-1:0] mode, input logic [RING_W-1:0] ring,
      input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stamp,
      input logic [BIN_W-1:0] bn);
    latency_result_t res;
    logic [TIME_W-1:0] divisor;
    logic [TIME_W-1:0] age;
    int slot;
    res = '0;
    if (int'(ring) < RINGS) begin
      case (mode)
        MODE_STAMP: begin
          gap_sum[ring] = gap_sum[ring] + (now - last_seen[ring]);
          if (gap_sum[ring] >= interval_reg) begin
            res.stamped = 1'b1;
            res.stamp_value = now;
            gap_sum[ring] = '0;
          end
          last_seen[ring] = now;
        end
        MODE_MEASURE: begin
          if (stamp != '0) begin
            divisor = (ns_divisor == '0) ? 64'd1 : 64'(ns_divisor);
            age = (now - stamp) / divisor;
            slot = (age < 64'(SLOTS - 1)) ? int'(age) : SLOTS - 1;
            hist_count[int'(ring)*SLOTS + slot] = hist_count[int'(ring)*SLOTS + slot] + 1;
          end
        end
        MODE_READ: begin
          if (int'(bn) < SLOTS) res.bin_count = hist_count[int'(ring)*SLOTS + int'(bn)];
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [RING_W-1:0] ring,
                           input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] stamp,
                           input logic [BIN_W-1:0] bn, output latency_result_t res);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= mode;
    item_ch.ring <= ring;
    item_ch.now_time <= now;
    item_ch.packet_stamp <= stamp;
    item_ch.bin <= bn;
    do @(posedge clk); while (!item_ch.ready);
    res = predict_latency_result(mode, ring, now, stamp, bn);
    pending_results.push_back(res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [TIME_W-1:0] interval, input logic [TIME_W-1:0] divisor);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_SAMPLE_INTERVAL;
    cfg_data <= interval;
    @(posedge clk);
    interval_reg = interval;
    @(negedge clk);
    cfg_index <= REG_CYCLES_PER_NS;
    cfg_data <= divisor;
    @(posedge clk);
    ns_divisor = divisor[DIVISOR_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic check_directed_cases();
    latency_result_t scratch;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // reset config: interval 0, divisor 1
    send_word(MODE_STAMP, 4'd0, 64'd0, 64'd0, 10'd0, scratch);
    send_word(MODE_STAMP, 4'd15, '1, '1, '1, scratch);
    send_word(MODE_MEASURE, 4'd0, 64'd100, 64'd0, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd0, 64'd10, 64'd3, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd0, 64'd5, 64'd10, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd15, 64'd1023, 64'd1, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd15, 64'd1025, 64'd1, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd15, '1, '1, 10'd0, scratch);
    send_word(MODE_READ, 4'd0, 64'd0, 64'd0, 10'd7, scratch);
    send_word(MODE_READ, 4'd0, 64'd0, 64'd0, 10'd1023, scratch);
    send_word(MODE_READ, 4'd15, 64'd0, 64'd0, 10'd1022, scratch);
    send_word(MODE_READ, 4'd15, '1, '1, 10'd0, scratch);
    send_word(MODE_UNUSED, 4'd15, '1, '1, '1, scratch);
    drain_results();
    // widest interval, zero divisor
    load_config('1, 64'd0);
    send_word(MODE_STAMP, 4'd3, 64'd5, 64'd0, 10'd0, scratch);
    send_word(MODE_STAMP, 4'd3, '1, 64'd0, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd3, 64'd150, 64'd50, 10'd0, scratch);
    send_word(MODE_READ, 4'd3, 64'd0, 64'd0, 10'd100, scratch);
    drain_results();
    // largest divisor
    load_config(64'd1, 64'd127);
    send_word(MODE_STAMP, 4'd7, 64'd0, 64'd0, 10'd0, scratch);
    send_word(MODE_STAMP, 4'd7, 64'd1, 64'd0, 10'd0, scratch);
    send_word(MODE_MEASURE, 4'd7, 64'd1000 + 64'd761, 64'd1000, 10'd0, scratch);
    send_word(MODE_READ, 4'd7, 64'd0, 64'd0, 10'd5, scratch);
    drain_results();
  endtask

  task automatic run_random_traffic(input int count, input int idle_pct, input int stall_pct);
    latency_result_t res;
    open_stamp_t os;
    logic [RING_W-1:0] rg;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] div_eff;
    logic [BIN_W-1:0] bn;
    int kind;
    int lat_ns;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    div_eff = (ns_divisor == '0) ? 64'd1 : 64'(ns_divisor);
    for (int i = 0; i < count; i++) begin
      rg = RING_W'($urandom_range(RINGS - 1));
      kind = $urandom_range(99);
      if (kind < 10) begin
        // noise
        send_word(MODE_W'($urandom_range(3)), RING_W'($urandom), {$urandom, $urandom},
                  {$urandom, $urandom}, BIN_W'($urandom), res);
      end else if (kind < 50) begin
        if ($urandom_range(19) == 0) now = {$urandom, $urandom};
        else now = ring_clock[rg] + 64'($urandom_range(400));
        ring_clock[rg] = now;
        send_word(MODE_STAMP, rg, now, {$urandom, $urandom}, BIN_W'($urandom), res);
        if (res.stamped && res.stamp_value != '0) begin
          os.ring = rg;
          os.stamp = res.stamp_value;
          open_stamps.push_back(os);
          if (open_stamps.size() > 64) void'(open_stamps.pop_front());
        end
      end else if (kind < 78) begin
        if (open_stamps.size() != 0 && $urandom_range(9) != 0) begin
          os = open_stamps.pop_front();
          rg = os.ring;
          stamp = os.stamp;
        end else if ($urandom_range(1) == 0) begin
          stamp = '0;
        end else begin
          stamp = {$urandom, $urandom};
        end
        lat_ns = $urandom_range(1100);
        if ($urandom_range(9) == 0) now = {$urandom, $urandom};
        else now = stamp + 64'(lat_ns) * div_eff + 64'($urandom_range(int'(div_eff) - 1));
        recent_bin[rg] = (lat_ns < SLOTS - 1) ? BIN_W'(lat_ns) : BIN_W'(SLOTS - 1);
        send_word(MODE_MEASURE, rg, now, stamp, BIN_W'($urandom), res);
      end else begin
        bn = ($urandom_range(9) < 7) ? recent_bin[rg] : BIN_W'($urandom);
        send_word(MODE_READ, rg, {$urandom, $urandom}, {$urandom, $urandom}, bn, res);
      end
    end
  endtask

  task automatic check_output_backpressure();
    latency_result_t scratch;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 400;
    for (int i = 0; i < 16; i++) begin
      send_word(MODE_W'($urandom_range(2)), RING_W'($urandom), 64'($urandom_range(2000)),
                64'($urandom_range(1000)), BIN_W'($urandom_range(20)), scratch);
    end
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin : result_check
    latency_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, actual stamped=%0b stamp_value=%h bin_count=%h",
                 $time, result_ch.stamped, result_ch.stamp_value, result_ch.bin_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.stamped !== want.stamped) begin
          $display("%0t: stamped expected %0b actual %0b", $time, want.stamped,
                   result_ch.stamped);
          mismatch_count++;
        end
        if (result_ch.stamp_value !== want.stamp_value) begin
          $display("%0t: stamp_value expected %h actual %h", $time, want.stamp_value,
                   result_ch.stamp_value);
          mismatch_count++;
        end
        if (result_ch.bin_count !== want.bin_count) begin
          $display("%0t: bin_count expected %h actual %h", $time, want.bin_count,
                   result_ch.bin_count);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  initial begin
    idle_count = 0;
    while (idle_count < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
        idle_count = 0;
      else
        idle_count++;
    end
    $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.mode = '0;
    item_ch.ring = '0;
    item_ch.now_time = '0;
    item_ch.packet_stamp = '0;
    item_ch.bin = '0;
    result_ch.ready = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    clear_shadow();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_directed_cases();

    load_config(64'd100, 64'd4);
    run_random_traffic(480, 0, 0);
    drain_results();
    load_config(64'd0, 64'd1);
    run_random_traffic(480, 69, 0);
    drain_results();
    load_config(64'd1000, 64'd64);
    run_random_traffic(480, 0, 69);
    drain_results();
    load_config(64'd37, 64'd127);
    run_random_traffic(480, 26, 26);
    drain_results();

    check_output_backpressure();
    drain_results();

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
